/* src/tri_element_stiffness_macros.svh */
// ----------------------------------------------------------------------------
// Triangle element stiffness: assertion macros
// Shared concurrent assertion forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef TRI_ELEMENT_STIFFNESS_MACROS_SVH
`define TRI_ELEMENT_STIFFNESS_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define TSE_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define TSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/tse_pkg.sv */
// ----------------------------------------------------------------------------
// Triangle element stiffness package
// Types, widths, register codes and helpers shared by the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tse_pkg;

    // Default parameter values.
    localparam int NODE_COUNT_DEF = 1024;
    localparam int FRAC_BITS_DEF  = 16;

    // Field widths.
    localparam int VTX_W     = 10;
    localparam int COORD_W   = 32;
    localparam int DIFF_W    = 33;
    localparam int MAG_W     = 34;
    localparam int PROD_W    = 2 * MAG_W;
    localparam int DMAG_W    = 67;
    localparam int DMAG_LO_W = 34;
    localparam int DIV_NW    = 100;
    localparam int DIV_DW    = 68;
    localparam int ACC_W     = 102;
    localparam int MIN_DET_W = 63;

    // Division by three through a reciprocal: floor(x / 3) equals
    // (x * RECIP3) >> RECIP_SH for any x below 2^35.
    localparam int               RECIP_SH = 35;
    localparam logic [MAG_W-1:0] RECIP3   = 34'h2_AAAA_AAAB;

    // Configuration port.
    localparam int CFG_DW = 64;
    localparam int CFG_AW = 4;
    localparam logic REG_MIN_DET = 1'b0;

    // Sequencer states.
    typedef enum logic [4:0] {
        S_IDLE,
        S_RD_A,
        S_RD_B,
        S_RD_C,
        S_CAP_C,
        S_DET1,
        S_DET2,
        S_DET3,
        S_CHK,
        S_M1,
        S_M2,
        S_M3,
        S_MD1,
        S_MD2,
        S_E1,
        S_E2,
        S_E3,
        S_E4,
        S_E5,
        S_OUT
    } t_state;

    // Input item.
    typedef struct packed {
        logic                      mode;
        logic [VTX_W-1:0]          vertex_a;
        logic [VTX_W-1:0]          vertex_b;
        logic [VTX_W-1:0]          vertex_c;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] slope;
        logic                      nonlinear;
    } t_in_item;

    // Result item.
    typedef struct packed {
        logic [1:0]                row;
        logic [1:0]                col;
        logic signed [COORD_W-1:0] entry;
        logic                      last;
        logic                      degenerate;
    } t_out_item;

    // Magnitude of a signed coordinate difference.
    function automatic logic [MAG_W-1:0] mag_diff(input logic signed [DIFF_W-1:0] v);
        logic signed [MAG_W-1:0] e;
        e = MAG_W'(v);
        return v[DIFF_W-1] ? MAG_W'(-e) : MAG_W'(e);
    endfunction

endpackage

`default_nettype wire

/* src/tse_stream_if.sv */
// ----------------------------------------------------------------------------
// Stream channel interface
// Valid/ready channel carrying one item of type T.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tse_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* src/tse_div.sv */
// ----------------------------------------------------------------------------
// Serial divider
// Restoring unsigned division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tse_div
    import tse_pkg::*;
#(
    parameter int NW = DIV_NW,
    parameter int DW = DIV_DW
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output logic               o_done,
    output logic [NW-1:0]      o_quo
);

    localparam int CW = $clog2(NW + 1);

    logic [CW-1:0] r_cnt;
    logic          r_done;
    logic [NW-1:0] r_num;
    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [DW:0]   w_trial;
    logic [DW:0]   w_diff;
    logic          w_ge;

    // Trial subtraction of the divisor from the shifted remainder.
    always_comb begin
        w_trial = {r_rem, r_num[NW-1]};
        w_diff  = w_trial - {1'b0, r_den};
        w_ge    = (w_trial >= {1'b0, r_den});
    end

    // Step counter and completion pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CW'(NW);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Dividend shift, remainder and quotient.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_cnt != '0) begin
            r_num <= {r_num[NW-2:0], 1'b0};
            r_rem <= w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
            r_quo <= {r_quo[NW-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

`default_nettype wire

/* src/tri_element_stiffness.sv */
// ----------------------------------------------------------------------------
// Triangle element stiffness
// P1 Laplace stiffness with optional mass term from a node coordinate store.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake        Content
//  i_item    in   valid/ready      node write (mode 0) or element (mode 1)
//  o_res     out  valid/ready      one stiffness entry or a degenerate flag
//  APB       in   psel/penable     min_det register at byte address 0
//
// An element reads its three nodes and forms the determinant; a degenerate
// one gives a single flag, otherwise nine entries follow from the serial
// divider, one quotient bit per cycle, after the mass quotient digit loop
// when the mass term is on. One item is in work at a time.
// Reset is synchronous and active low; the node store is not cleared.
// A stalled result holds the block in place until it is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tri_element_stiffness
    import tse_pkg::*;
#(
    parameter int NODE_COUNT = NODE_COUNT_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    tse_stream_if.sink             i_item,
    tse_stream_if.source           o_res,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [CFG_AW-1:0] paddr,
    input  wire logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0]      prdata,
    output logic                   pready
);

    `include "tri_element_stiffness_macros.svh"

    localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

    // Mass denominator 24 * 2^(2F) is 3 * 2^MSH; the quotient by three is
    // formed one 32-bit digit at a time.
    localparam int MSH = 2 * FRAC_BITS + 3;
    localparam int QW  = DIV_NW - MSH;
    localparam int ND  = (QW + 31) / 32;
    localparam int QPW = ND * 32;
    localparam int DGW = (ND > 1) ? $clog2(ND) : 1;

    t_state r_state, n_state;

    // Configuration.
    logic [MIN_DET_W-1:0] r_min_det;

    // Item latch.
    logic [VTX_W-1:0]          r_va, r_vb, r_vc;
    logic                      r_ok_a, r_ok_b, r_ok_c;
    logic signed [COORD_W-1:0] r_slope;
    logic                      r_nonlin;

    // Node store and read data.
    logic [COORD_W-1:0] mem_x [NODE_COUNT];
    logic [COORD_W-1:0] mem_y [NODE_COUNT];
    logic [AW-1:0]      w_raddr;
    logic [COORD_W-1:0] r_rd_x, r_rd_y;
    logic signed [COORD_W-1:0] r_x0, r_y0, r_x1, r_y1, r_x2, r_y2;

    // Datapath.
    logic signed [DIFF_W-1:0] w_b [3];
    logic signed [DIFF_W-1:0] w_c [3];
    logic signed [DIFF_W-1:0] w_dx1, w_dy1, w_dx2, w_dy2;
    logic [MAG_W-1:0]         w_ma, w_mb;
    logic                     w_mneg;
    logic [PROD_W-1:0]        r_prod;
    logic                     r_pneg;
    logic signed [ACC_W-1:0]  w_pext, w_sprod, w_aabs;
    logic signed [ACC_W-1:0]  r_acc;
    logic [DMAG_W-1:0]        w_dmag, r_dmag;
    logic                     w_degen;
    logic [MAG_W-1:0]         w_slope_mag;
    logic [DIV_NW-1:0]        r_n1, r_n2;
    logic                     r_nneg;
    logic [1:0]               r_i, r_j;

    // Mass term digit loop.
    logic [DIV_NW-1:0] w_mnum;
    logic [QPW-1:0]    w_mq;
    logic [31:0]       w_mdig;
    logic [MAG_W-1:0]  w_mx;
    logic [31:0]       w_mt;
    logic [MAG_W-1:0]  w_mrem;
    logic [1:0]        r_mrem;
    logic [DGW-1:0]    r_dig;
    logic              r_pass;
    logic [QPW-1:0]    r_qacc;

    // Divider hookup.
    logic              w_div_start, w_div_done;
    logic [DIV_NW-1:0] w_div_num, w_div_quo;
    logic [DIV_DW-1:0] w_div_den;

    // Entry assembly.
    logic signed [ACC_W-1:0] w_lq, w_nq, w_val;
    logic [DIV_NW-1:0]       w_nsel;
    logic signed [COORD_W-1:0] w_sat;
    t_out_item r_out;

    logic w_in_fire, w_out_fire, w_cfg_wr;

    assign w_in_fire  = i_item.valid && i_item.ready;
    assign w_out_fire = o_res.valid && o_res.ready;

    // APB register access.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_det <= MIN_DET_W'(1);
        end else if (w_cfg_wr && (paddr[3] == REG_MIN_DET) && (paddr[2:0] == 3'd0)) begin
            r_min_det <= pwdata[MIN_DET_W-1:0];
        end
    end

    always_comb begin
        if (paddr[3] == REG_MIN_DET) begin
            prdata = {1'b0, r_min_det};
        end else begin
            prdata = '0;
        end
    end

    // Node store write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (w_in_fire && !i_item.data.mode && (32'(i_item.data.vertex_a) < NODE_COUNT)) begin
            mem_x[AW'(i_item.data.vertex_a)] <= i_item.data.coord_x;
            mem_y[AW'(i_item.data.vertex_a)] <= i_item.data.coord_y;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_x <= mem_x[w_raddr];
        r_rd_y <= mem_y[w_raddr];
    end

    // Coordinate differences and triangle edge vectors.
    always_comb begin
        w_dx1 = DIFF_W'(r_x1) - DIFF_W'(r_x0);
        w_dy1 = DIFF_W'(r_y1) - DIFF_W'(r_y0);
        w_dx2 = DIFF_W'(r_x2) - DIFF_W'(r_x0);
        w_dy2 = DIFF_W'(r_y2) - DIFF_W'(r_y0);
        w_b[0] = DIFF_W'(r_y1) - DIFF_W'(r_y2);
        w_b[1] = DIFF_W'(r_y2) - DIFF_W'(r_y0);
        w_b[2] = DIFF_W'(r_y0) - DIFF_W'(r_y1);
        w_c[0] = DIFF_W'(r_x2) - DIFF_W'(r_x1);
        w_c[1] = DIFF_W'(r_x0) - DIFF_W'(r_x2);
        w_c[2] = DIFF_W'(r_x1) - DIFF_W'(r_x0);
    end

    // Signed views of the product and accumulator.
    always_comb begin
        w_pext      = {{(ACC_W-PROD_W){1'b0}}, r_prod};
        w_sprod     = r_pneg ? -w_pext : w_pext;
        w_aabs      = r_acc[ACC_W-1] ? -r_acc : r_acc;
        w_dmag      = w_aabs[DMAG_W-1:0];
        w_degen     = (w_dmag == '0) || (w_dmag < {{(DMAG_W-MIN_DET_W){1'b0}}, r_min_det});
        w_slope_mag = r_slope[COORD_W-1] ? MAG_W'(-MAG_W'(r_slope)) : MAG_W'(r_slope);
    end

    // Mass quotient: add half the denominator, drop the power of two, then
    // divide by three one digit at a time, top digit first, carrying the
    // remainder into the next digit.
    always_comb begin
        w_mnum = (r_pass ? {r_acc[DIV_NW-2:0], 1'b0} : r_acc[DIV_NW-1:0])
                 + (DIV_NW'(3) << (MSH - 1));
        w_mq   = QPW'(w_mnum >> MSH);
        w_mdig = w_mq[32*r_dig +: 32];
        w_mx   = {r_mrem, w_mdig};
        w_mt   = r_prod[RECIP_SH +: 32];
        w_mrem = w_mx - (MAG_W'(w_mt) + (MAG_W'(w_mt) << 1));
    end

    // Entry value: rounded Laplace part less the mass part, then saturation.
    always_comb begin
        w_lq   = {{(ACC_W-DIV_NW){1'b0}}, w_div_quo};
        w_lq   = r_nneg ? -w_lq : w_lq;
        w_nsel = (r_i == r_j) ? r_n2 : r_n1;
        w_nq   = {{(ACC_W-DIV_NW){1'b0}}, w_nsel};
        w_nq   = r_slope[COORD_W-1] ? -w_nq : w_nq;
        w_val  = r_nonlin ? (w_lq - w_nq) : w_lq;
        if (w_val > ACC_W'(signed'(32'h7FFF_FFFF))) begin
            w_sat = 32'sh7FFF_FFFF;
        end else if (w_val < -ACC_W'(signed'(33'sh0_8000_0000))) begin
            w_sat = 32'sh8000_0000;
        end else begin
            w_sat = w_val[COORD_W-1:0];
        end
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_in_fire && i_item.data.mode) n_state = S_RD_A;
            S_RD_A:  n_state = S_RD_B;
            S_RD_B:  n_state = S_RD_C;
            S_RD_C:  n_state = S_CAP_C;
            S_CAP_C: n_state = S_DET1;
            S_DET1:  n_state = S_DET2;
            S_DET2:  n_state = S_DET3;
            S_DET3:  n_state = S_CHK;
            S_CHK: begin
                if (w_degen) n_state = S_OUT;
                else if (r_nonlin) n_state = S_M1;
                else n_state = S_E1;
            end
            S_M1:    n_state = S_M2;
            S_M2:    n_state = S_M3;
            S_M3:    n_state = S_MD1;
            S_MD1:   n_state = S_MD2;
            S_MD2:   n_state = ((r_dig == '0) && r_pass) ? S_E1 : S_MD1;
            S_E1:    n_state = S_E2;
            S_E2:    n_state = S_E3;
            S_E3:    n_state = S_E4;
            S_E4:    n_state = S_E5;
            S_E5:    if (w_div_done) n_state = S_OUT;
            S_OUT: begin
                if (w_out_fire) n_state = r_out.last ? S_IDLE : S_E1;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State-driven controls: read address, multiplier operands, divider start.
    always_comb begin
        i_item.ready = (r_state == S_IDLE);
        o_res.valid  = (r_state == S_OUT);
        o_res.data   = r_out;
        w_raddr      = AW'(r_va);
        w_ma         = '0;
        w_mb         = '0;
        w_mneg       = 1'b0;
        w_div_start  = 1'b0;
        w_div_num    = '0;
        w_div_den    = '0;
        unique case (r_state)
            S_RD_B: w_raddr = AW'(r_vb);
            S_RD_C: w_raddr = AW'(r_vc);
            S_DET1: begin
                w_ma   = mag_diff(w_dx1);
                w_mb   = mag_diff(w_dy2);
                w_mneg = w_dx1[DIFF_W-1] ^ w_dy2[DIFF_W-1];
            end
            S_DET2: begin
                w_ma   = mag_diff(w_dx2);
                w_mb   = mag_diff(w_dy1);
                w_mneg = w_dx2[DIFF_W-1] ^ w_dy1[DIFF_W-1];
            end
            S_M1: begin
                w_ma = MAG_W'(r_dmag[DMAG_LO_W-1:0]);
                w_mb = w_slope_mag;
            end
            S_M2: begin
                w_ma = MAG_W'(r_dmag[DMAG_W-1:DMAG_LO_W]);
                w_mb = w_slope_mag;
            end
            S_MD1: begin
                w_ma = w_mx;
                w_mb = RECIP3;
            end
            S_E1: begin
                w_ma   = mag_diff(w_b[r_i]);
                w_mb   = mag_diff(w_b[r_j]);
                w_mneg = w_b[r_i][DIFF_W-1] ^ w_b[r_j][DIFF_W-1];
            end
            S_E2: begin
                w_ma   = mag_diff(w_c[r_i]);
                w_mb   = mag_diff(w_c[r_j]);
                w_mneg = w_c[r_i][DIFF_W-1] ^ w_c[r_j][DIFF_W-1];
            end
            S_E4: begin
                w_div_start = 1'b1;
                w_div_num   = (w_aabs[DIV_NW-1:0] << FRAC_BITS) + DIV_NW'(r_dmag);
                w_div_den   = DIV_DW'({r_dmag, 1'b0});
            end
            default: ;
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_i     <= '0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CHK) begin
                r_i <= '0;
                r_j <= '0;
            end else if ((r_state == S_OUT) && w_out_fire) begin
                if (r_j == 2'd2) begin
                    r_j <= '0;
                    r_i <= r_i + 1'b1;
                end else begin
                    r_j <= r_j + 1'b1;
                end
            end
        end
    end

    // Item latch, node capture, products and accumulator.
    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
        r_pneg <= w_mneg;
        if (w_in_fire) begin
            r_va     <= i_item.data.vertex_a;
            r_vb     <= i_item.data.vertex_b;
            r_vc     <= i_item.data.vertex_c;
            r_ok_a   <= (32'(i_item.data.vertex_a) < NODE_COUNT);
            r_ok_b   <= (32'(i_item.data.vertex_b) < NODE_COUNT);
            r_ok_c   <= (32'(i_item.data.vertex_c) < NODE_COUNT);
            r_slope  <= i_item.data.slope;
            r_nonlin <= i_item.data.nonlinear;
        end
        case (r_state)
            S_RD_B: begin
                r_x0 <= r_ok_a ? r_rd_x : '0;
                r_y0 <= r_ok_a ? r_rd_y : '0;
            end
            S_RD_C: begin
                r_x1 <= r_ok_b ? r_rd_x : '0;
                r_y1 <= r_ok_b ? r_rd_y : '0;
            end
            S_CAP_C: begin
                r_x2 <= r_ok_c ? r_rd_x : '0;
                r_y2 <= r_ok_c ? r_rd_y : '0;
            end
            S_DET2:  r_acc <= w_sprod;
            S_DET3:  r_acc <= r_acc - w_sprod;
            S_CHK: begin
                r_dmag <= w_dmag;
                if (w_degen) begin
                    r_out <= '{row: 2'd0, col: 2'd0, entry: '0, last: 1'b1, degenerate: 1'b1};
                end
            end
            S_M2:    r_acc <= w_pext;
            S_M3: begin
                r_acc  <= r_acc + (w_pext << DMAG_LO_W);
                r_pass <= 1'b0;
                r_dig  <= DGW'(ND - 1);
                r_mrem <= '0;
            end
            S_MD2: begin
                r_qacc <= {r_qacc[QPW-33:0], w_mt};
                if (r_dig == '0) begin
                    if (r_pass) begin
                        r_n2 <= DIV_NW'({r_qacc[QPW-33:0], w_mt});
                    end else begin
                        r_n1 <= DIV_NW'({r_qacc[QPW-33:0], w_mt});
                    end
                    r_pass <= 1'b1;
                    r_dig  <= DGW'(ND - 1);
                    r_mrem <= '0;
                end else begin
                    r_dig  <= r_dig - 1'b1;
                    r_mrem <= w_mrem[1:0];
                end
            end
            S_E2:    r_acc <= w_sprod;
            S_E3:    r_acc <= r_acc + w_sprod;
            S_E4:    r_nneg <= r_acc[ACC_W-1];
            S_E5: begin
                if (w_div_done) begin
                    r_out <= '{row: r_i, col: r_j, entry: w_sat,
                               last: (r_i == 2'd2) && (r_j == 2'd2), degenerate: 1'b0};
                end
            end
            default: ;
        endcase
    end

    // Shared serial divider.
    tse_div #(
        .NW (DIV_NW),
        .DW (DIV_DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    // Checks on the sequencer.
    `TSE_ASSERT_SAME(a_degen_last, i_clk, i_rst_n, o_res.valid && o_res.data.degenerate,
        o_res.data.last, "degenerate result without last")
    `TSE_ASSERT_SAME(a_one_item, i_clk, i_rst_n, i_item.ready, !o_res.valid,
        "input taken while a result is pending")
    `TSE_ASSERT_NEXT(a_last_idle, i_clk, i_rst_n, w_out_fire && o_res.data.last,
        i_item.ready, "block not idle after final result")
    `TSE_ASSERT_SAME(a_entry_pos, i_clk, i_rst_n, o_res.valid && !o_res.data.degenerate,
        (o_res.data.row != 2'd3) && (o_res.data.col != 2'd3), "entry position out of range")

endmodule

`default_nettype wire
